FILE: rtl/twfp_pkg.sv
package twfp_pkg;

   localparam int MAX_CHUNKS = 64;
   localparam int CHUNK_AW   = $clog2(MAX_CHUNKS);
   localparam int CHUNK_CW   = $clog2(MAX_CHUNKS + 1);

   localparam int CSR_IW = 8;
   localparam int CSR_DW = 20;

   localparam logic [CSR_IW-1:0] REG_REF_UNIT   = 8'd0;
   localparam logic [CSR_IW-1:0] REG_DELTA_UNIT = 8'd1;

   localparam logic [19:0] REF_UNIT_RESET   = 20'd64000;
   localparam logic [15:0] DELTA_UNIT_RESET = 16'd250;

   localparam logic [12:0] VEC2_LEN = 13'd7;
   localparam logic [12:0] VEC1_LEN = 13'd14;

   typedef enum logic [1:0] {
      KIND_RECV = 2'd0,
      KIND_LOST = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        first_sn;
      logic [15:0]        packet_total;
      logic signed [47:0] remote_time;
      logic               frame_status;
   } result_type;

   // Number of symbols a status chunk carries.
   function automatic logic [12:0] chunk_len(input logic [15:0] c);
      if (!c[15]) begin
         return c[12:0];
      end else if (c[14]) begin
         return VEC2_LEN;
      end
      return VEC1_LEN;
   endfunction

   // Symbol at a given offset inside a chunk.
   function automatic logic [1:0] symbol_of(input logic [15:0] c, input logic [12:0] off);
      logic [3:0]  sh;
      logic [15:0] s;
      sh = '0;
      s  = '0;
      if (!c[15]) begin
         return c[14:13];
      end
      if (c[14]) begin
         if (off < VEC2_LEN) begin
            sh = 4'd12 - {off[2:0], 1'b0};
            s  = c >> sh;
            return s[1:0];
         end
         return 2'd0;
      end
      if (off < VEC1_LEN) begin
         sh = 4'd13 - off[3:0];
         s  = c >> sh;
         return {1'b0, s[0]};
      end
      return 2'd0;
   endfunction

endpackage

FILE: rtl/twfp_req_if.sv
interface twfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_last;

   modport source (output valid, output data_byte, output frame_last, input ready);
   modport sink (input valid, input data_byte, input frame_last, output ready);
endinterface

FILE: rtl/twfp_rsp_if.sv
interface twfp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic [15:0]        first_sn;
   logic [15:0]        packet_total;
   logic signed [47:0] remote_time;
   logic               frame_status;
   logic               run_last;

   modport source (output valid, output result_kind, output first_sn, output packet_total,
                   output remote_time, output frame_status, output run_last, input ready);
   modport sink (input valid, input result_kind, input first_sn, input packet_total,
                 input remote_time, input frame_status, input run_last, output ready);
endinterface

FILE: rtl/twfp_csr_if.sv
interface twfp_csr_if;
   import twfp_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_IW-1:0] index;
   logic [CSR_DW-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/twfp_ram.sv
module twfp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/twfp_outbuf.sv
// Holds the newest result back until it is known whether it is the last one of its byte.
module twfp_outbuf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 emit_valid,
   input  twfp_pkg::result_type emit_item,
   output logic                 emit_ready,
   input  logic                 close_valid,
   output logic                 close_ready,
   twfp_rsp_if.source           rsp_chan
);
   import twfp_pkg::*;

   result_type pend_ff;
   logic       pend_valid_ff;
   result_type out_ff;
   logic       out_last_ff;
   logic       out_valid_ff;
   logic       out_free;

   assign out_free    = !out_valid_ff || rsp_chan.ready;
   assign emit_ready  = !pend_valid_ff || out_free;
   assign close_ready = emit_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (emit_valid && emit_ready) begin
            if (pend_valid_ff) begin
               out_ff       <= pend_ff;
               out_last_ff  <= 1'b0;
               out_valid_ff <= 1'b1;
            end else if (out_valid_ff && rsp_chan.ready) begin
               out_valid_ff <= 1'b0;
            end
            pend_ff       <= emit_item;
            pend_valid_ff <= 1'b1;
         end else if (close_valid && close_ready && pend_valid_ff) begin
            out_ff        <= pend_ff;
            out_last_ff   <= 1'b1;
            out_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end else if (out_valid_ff && rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_kind  = out_ff.kind;
   assign rsp_chan.first_sn     = out_ff.first_sn;
   assign rsp_chan.packet_total = out_ff.packet_total;
   assign rsp_chan.remote_time  = out_ff.remote_time;
   assign rsp_chan.frame_status = out_ff.frame_status;
   assign rsp_chan.run_last     = out_last_ff;
endmodule

FILE: rtl/twfp_feedback_parser.sv
// Channel | Dir | Carries
// --------+-----+---------------------------------------------------------
// req     | in  | one payload byte per item, with the frame-last flag
// rsp     | out | received, lost-run and frame-end results, run_last marked
// csr     | in  | register writes: index 0 reference unit, 1 delta unit
//
// On its last byte a delta passes the multiply, add, flush and receive states.
// Walking the status symbols after a delta reads each new chunk from the chunk
// memory and steps one vector symbol or one whole run at a time.
// Reset is synchronous and needs no clearing pass; the chunk memory is only
// read where it has been written for the current frame.
// A stalled result channel holds the sequencer only once two results wait.
module twcc_feedback_parser (
   input  logic      clock,
   input  logic      reset,
   twfp_req_if.sink  req_chan,
   twfp_rsp_if.source rsp_chan,
   twfp_csr_if.sink  csr_chan
);
   import twfp_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER, PH_CHUNKS, PH_DELTAS, PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE, S_CHUNK, S_REFMUL, S_WREAD, S_WWAIT, S_WSTEP, S_WEND,
      S_DMUL, S_DADD, S_DFLUSH, S_DRECV, S_LFLUSH, S_LEND, S_CLOSE
   } state_type;

   state_type          state_ff;
   phase_type          phase_ff;
   logic [3:0]         pos_ff;
   logic [15:0]        base_ff;
   logic [15:0]        declared_ff;
   logic [47:0]        running_ff;
   logic [23:0]        ref24_ff;
   logic [CHUNK_CW-1:0] loaded_ff;
   logic [15:0]        covered_ff;
   logic [CHUNK_CW-1:0] walk_ff;
   logic [12:0]        off_ff;
   logic [15:0]        seq_ff;
   logic [15:0]        left_ff;
   logic [7:0]         high_ff;
   logic [15:0]        lost_start_ff;
   logic [15:0]        lost_len_ff;
   logic [7:0]         byte_ff;
   logic               last_ff;
   logic [15:0]        chunk_ff;
   logic signed [15:0] delta_ff;
   logic signed [32:0] prod_ff;
   logic [19:0]        ref_unit_ff;
   logic [15:0]        delta_unit_ff;

   // Chunk being loaded and the packets it newly covers.
   logic [15:0]         chunk_new;
   logic [15:0]         new_len;
   logic [15:0]         need;
   logic [15:0]         new_cnt;
   logic [15:0]         new_cov;
   logic [CHUNK_CW-1:0] loaded_nx;

   // Position inside the chunk under the walk.
   logic [12:0] cur_len;
   logic [12:0] rem;
   logic [12:0] avail;
   logic [12:0] step_n;
   logic [1:0]  cur_sym;

   logic signed [44:0] ref_prod;
   logic signed [32:0] delta_prod;
   logic [15:0]        ram_rdata;

   logic       emit_valid;
   logic       emit_ready;
   result_type emit_item;
   logic       close_valid;
   logic       close_ready;
   logic       go;
   logic       req_take;

   assign chunk_new = {high_ff, byte_ff};
   assign new_len   = {3'b000, chunk_len(chunk_new)};
   assign need      = declared_ff - covered_ff;
   assign new_cnt   = (new_len > need) ? need : new_len;
   assign new_cov   = covered_ff + new_cnt;
   assign loaded_nx = loaded_ff + 1'b1;

   assign cur_len = chunk_len(chunk_ff);
   assign rem     = (cur_len > off_ff) ? cur_len - off_ff : 13'd0;
   assign avail   = ({3'b000, rem} > left_ff) ? left_ff[12:0] : rem;
   assign cur_sym = symbol_of(chunk_ff, off_ff);
   assign step_n  = chunk_ff[15] ? 13'd1 : avail;

   assign ref_prod   = $signed(ref24_ff) * $signed({1'b0, ref_unit_ff});
   assign delta_prod = delta_ff * $signed({1'b0, delta_unit_ff});

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   twfp_ram #(.WIDTH(16), .DEPTH(MAX_CHUNKS)) u_chunks (
      .clock   (clock),
      .wr_en   (state_ff == S_CHUNK),
      .wr_addr (loaded_ff[CHUNK_AW-1:0]),
      .wr_data (chunk_new),
      .rd_addr (walk_ff[CHUNK_AW-1:0]),
      .rd_data (ram_rdata)
   );

   twfp_outbuf u_outbuf (
      .clock       (clock),
      .reset       (reset),
      .emit_valid  (emit_valid),
      .emit_item   (emit_item),
      .emit_ready  (emit_ready),
      .close_valid (close_valid),
      .close_ready (close_ready),
      .rsp_chan    (rsp_chan)
   );

   // Result requests of the sequencer. A pending lost stretch is flushed
   // ahead of a received packet, at the end of the walk and at frame end.
   always_comb begin
      emit_valid = 1'b0;
      close_valid = (state_ff == S_CLOSE);
      emit_item.kind         = KIND_LOST;
      emit_item.first_sn     = lost_start_ff;
      emit_item.packet_total = lost_len_ff;
      emit_item.remote_time  = '0;
      emit_item.frame_status = 1'b0;
      unique case (state_ff)
         S_WEND, S_DFLUSH: begin
            emit_valid = (lost_len_ff != 16'd0);
         end
         S_LFLUSH: begin
            emit_valid = last_ff && (lost_len_ff != 16'd0);
         end
         S_DRECV: begin
            emit_valid             = 1'b1;
            emit_item.kind         = KIND_RECV;
            emit_item.first_sn     = seq_ff;
            emit_item.packet_total = 16'd1;
            emit_item.remote_time  = $signed(running_ff);
         end
         S_LEND: begin
            emit_valid             = 1'b1;
            emit_item.kind         = KIND_END;
            emit_item.first_sn     = '0;
            emit_item.packet_total = '0;
            emit_item.frame_status = (phase_ff != PH_DONE);
         end
         default: begin
         end
      endcase
   end

   assign go = !emit_valid || emit_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         base_ff       <= '0;
         declared_ff   <= '0;
         running_ff    <= '0;
         loaded_ff     <= '0;
         covered_ff    <= '0;
         walk_ff       <= '0;
         off_ff        <= '0;
         seq_ff        <= '0;
         left_ff       <= '0;
         high_ff       <= '0;
         lost_start_ff <= '0;
         lost_len_ff   <= '0;
         last_ff       <= 1'b0;
         ref_unit_ff   <= REF_UNIT_RESET;
         delta_unit_ff <= DELTA_UNIT_RESET;
      end else begin
         if (csr_chan.valid) begin
            if (csr_chan.index == REG_REF_UNIT) begin
               ref_unit_ff <= csr_chan.data[19:0];
            end else if (csr_chan.index == REG_DELTA_UNIT) begin
               delta_unit_ff <= csr_chan.data[15:0];
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  byte_ff  <= req_chan.data_byte;
                  last_ff  <= req_chan.frame_last;
                  state_ff <= S_LFLUSH;
                  unique case (phase_ff)
                     PH_HEADER: begin
                        priority case (pos_ff)
                           4'd4: base_ff[15:8] <= req_chan.data_byte;
                           4'd5: base_ff[7:0] <= req_chan.data_byte;
                           4'd6: declared_ff[15:8] <= req_chan.data_byte;
                           4'd7: declared_ff[7:0] <= req_chan.data_byte;
                           4'd8: ref24_ff <= {16'd0, req_chan.data_byte};
                           4'd9, 4'd10: ref24_ff <= {ref24_ff[15:0], req_chan.data_byte};
                           default: begin
                           end
                        endcase
                        if (pos_ff >= 4'd11) begin
                           pos_ff     <= '0;
                           covered_ff <= '0;
                           loaded_ff  <= '0;
                           phase_ff   <= (declared_ff == 16'd0) ? PH_DONE : PH_CHUNKS;
                        end else begin
                           pos_ff <= pos_ff + 4'd1;
                           if (pos_ff == 4'd10) begin
                              state_ff <= S_REFMUL;
                           end
                        end
                     end
                     PH_CHUNKS: begin
                        if (pos_ff == 4'd0) begin
                           high_ff <= req_chan.data_byte;
                           pos_ff  <= 4'd1;
                        end else begin
                           pos_ff   <= 4'd0;
                           state_ff <= S_CHUNK;
                        end
                     end
                     PH_DELTAS: begin
                        if (walk_ff >= loaded_ff || left_ff == 16'd0) begin
                           phase_ff <= PH_DONE;
                        end else if (cur_sym == 2'd1) begin
                           delta_ff <= $signed({{8{req_chan.data_byte[7]}},
                                                req_chan.data_byte});
                           state_ff <= S_DMUL;
                        end else if (cur_sym == 2'd2) begin
                           if (pos_ff == 4'd0) begin
                              high_ff <= req_chan.data_byte;
                              pos_ff  <= 4'd1;
                           end else begin
                              pos_ff   <= 4'd0;
                              delta_ff <= $signed({high_ff, req_chan.data_byte});
                              state_ff <= S_DMUL;
                           end
                        end
                     end
                     PH_DONE: begin
                     end
                  endcase
               end
            end
            S_REFMUL: begin
               // The 24-bit reference time is signed; the product fits in 45 bits.
               running_ff <= {{3{ref_prod[44]}}, ref_prod};
               state_ff   <= S_LFLUSH;
            end
            S_CHUNK: begin
               loaded_ff  <= loaded_nx;
               covered_ff <= new_cov;
               if (new_cov >= declared_ff || loaded_nx == CHUNK_CW'(MAX_CHUNKS)) begin
                  if (new_cov < declared_ff) begin
                     declared_ff <= new_cov;
                     left_ff     <= new_cov;
                  end else begin
                     left_ff <= declared_ff;
                  end
                  walk_ff     <= '0;
                  off_ff      <= '0;
                  seq_ff      <= base_ff;
                  lost_len_ff <= '0;
                  pos_ff      <= '0;
                  phase_ff    <= PH_DELTAS;
                  state_ff    <= S_WREAD;
               end else begin
                  state_ff <= S_LFLUSH;
               end
            end
            S_WREAD: begin
               if (left_ff == 16'd0) begin
                  state_ff <= S_WEND;
               end else if (walk_ff >= loaded_ff) begin
                  left_ff  <= '0;
                  state_ff <= S_WEND;
               end else begin
                  state_ff <= S_WWAIT;
               end
            end
            S_WWAIT: begin
               chunk_ff <= ram_rdata;
               state_ff <= S_WSTEP;
            end
            S_WSTEP: begin
               if (left_ff == 16'd0) begin
                  state_ff <= S_WEND;
               end else if (avail == 13'd0) begin
                  walk_ff  <= walk_ff + 1'b1;
                  off_ff   <= '0;
                  state_ff <= S_WREAD;
               end else if (cur_sym == 2'd1 || cur_sym == 2'd2) begin
                  // Delta symbol: wait for its bytes.
                  state_ff <= S_LFLUSH;
               end else begin
                  // Not received or reserved: folded into the lost stretch.
                  if (lost_len_ff == 16'd0) begin
                     lost_start_ff <= seq_ff;
                  end
                  lost_len_ff <= lost_len_ff + {3'b000, step_n};
                  seq_ff      <= seq_ff + {3'b000, step_n};
                  left_ff     <= left_ff - {3'b000, step_n};
                  off_ff      <= off_ff + step_n;
               end
            end
            S_WEND: begin
               if (go) begin
                  lost_len_ff <= '0;
                  phase_ff    <= PH_DONE;
                  state_ff    <= S_LFLUSH;
               end
            end
            S_DMUL: begin
               prod_ff  <= delta_prod;
               state_ff <= S_DADD;
            end
            S_DADD: begin
               running_ff <= running_ff + {{15{prod_ff[32]}}, prod_ff};
               state_ff   <= S_DFLUSH;
            end
            S_DFLUSH: begin
               if (go) begin
                  lost_len_ff <= '0;
                  state_ff    <= S_DRECV;
               end
            end
            S_DRECV: begin
               if (go) begin
                  seq_ff   <= seq_ff + 16'd1;
                  left_ff  <= left_ff - 16'd1;
                  off_ff   <= off_ff + 13'd1;
                  state_ff <= S_WSTEP;
               end
            end
            S_LFLUSH: begin
               if (!last_ff) begin
                  state_ff <= S_CLOSE;
               end else if (go) begin
                  lost_len_ff <= '0;
                  state_ff    <= S_LEND;
               end
            end
            S_LEND: begin
               if (go) begin
                  phase_ff    <= PH_HEADER;
                  pos_ff      <= '0;
                  loaded_ff   <= '0;
                  covered_ff  <= '0;
                  walk_ff     <= '0;
                  off_ff      <= '0;
                  left_ff     <= '0;
                  lost_len_ff <= '0;
                  state_ff    <= S_CLOSE;
               end
            end
            S_CLOSE: begin
               if (close_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // The sequencer never raises a result while it waits for a byte.
   a_idle_no_emit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !emit_valid)
      else $error("result requested while idle");

   // An accepted byte always starts work.
   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != S_IDLE)
      else $error("accepted byte left the sequencer idle");

   // The walk never passes the loaded chunks.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      walk_ff <= loaded_ff)
      else $error("walk beyond loaded chunks");

   // Waiting for delta bytes always means packets are still uncovered.
   a_delta_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && phase_ff == PH_DELTAS) |-> left_ff != 16'd0)
      else $error("delta phase with no packets left");
endmodule
